FILE: hw/rtl/task_table_round_robin_macros.svh
// assertion macros for the round-robin task table checker
`ifndef TASK_TABLE_ROUND_ROBIN_MACROS_SVH
`define TASK_TABLE_ROUND_ROBIN_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define TTRR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("task table check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define TTRR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("task table check failed");

`endif

FILE: hw/rtl/ttrr_pkg.sv
// shared types, codes and defaults for the round-robin task table
`timescale 1ns / 1ps

package ttrr_pkg;

    localparam int SLOTS_DEF = 16;

    // command codes
    localparam logic [1:0] CMD_CREATE    = 2'd0;
    localparam logic [1:0] CMD_TERMINATE = 2'd1;
    localparam logic [1:0] CMD_SCHEDULE  = 2'd2;

    // result status codes
    localparam logic [2:0] RES_OK        = 3'd0;
    localparam logic [2:0] RES_FULL      = 3'd1;
    localparam logic [2:0] RES_KERNEL    = 3'd2;
    localparam logic [2:0] RES_NOT_FOUND = 3'd3;
    localparam logic [2:0] RES_NO_READY  = 3'd4;

    // slot states
    localparam logic [1:0] SLOT_UNUSED     = 2'd0;
    localparam logic [1:0] SLOT_READY      = 2'd1;
    localparam logic [1:0] SLOT_RUNNING    = 2'd2;
    localparam logic [1:0] SLOT_TERMINATED = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] target_id;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  slot_index;
        logic [31:0] task_id;
        logic [3:0]  previous_slot;
    } res_t;

    typedef struct packed {
        logic        stat_we;
        logic [1:0]  stat;
        logic        id_we;
        logic [31:0] id;
    } slot_wr_t;

    typedef struct packed {
        logic [1:0]  stat;
        logic [31:0] id;
    } slot_rd_t;

endpackage

FILE: hw/rtl/task_table_round_robin.sv
// round-robin task table: create, terminate and schedule over a slot table
//
//  channel   dir  handshake              payload
//  cmd       in   cmd_valid / cmd_ready  cmd_data (cmd, target_id)
//  res       out  res_valid / res_ready  res_data (status, slot_index, task_id, previous_slot)
//
// each slot examined passes through S_LOAD and S_CHECK on the single memory read port;
// create and terminate add entry in S_IDLE and exit through S_RESULT
// schedule first reads the running slot, and adds S_WRITE for the second state write
// the table is usable straight after reset
// a waiting result does not block the next command; only its delivery waits
`timescale 1ns / 1ps

module task_table_round_robin #(
    parameter int SLOTS = ttrr_pkg::SLOTS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  ttrr_pkg::cmd_t cmd_data,
    output logic           res_valid,
    input  logic           res_ready,
    output ttrr_pkg::res_t res_data
);
    import ttrr_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam int EXT_W = (IDX_W > 4) ? IDX_W : 4;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOAD   = 3'd1;
    localparam logic [2:0] S_CHECK  = 3'd2;
    localparam logic [2:0] S_WRITE  = 3'd3;
    localparam logic [2:0] S_RESULT = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [1:0]       cmd_reg, cmd_next;
    logic [31:0]      target_reg, target_next;
    logic [IDX_W-1:0] addr_reg, addr_next;
    logic [IDX_W-1:0] count_reg, count_next;
    logic             first_reg, first_next;
    logic [IDX_W-1:0] cur_reg, cur_next;
    logic [1:0]       cur_stat_reg, cur_stat_next;
    logic [31:0]      cur_id_reg, cur_id_next;
    logic [IDX_W-1:0] running_reg, running_next;
    logic [31:0]      id_counter_reg, id_counter_next;
    res_t             res_reg, res_next;
    logic             res_valid_reg, res_valid_next;
    res_t             res_data_reg, res_data_next;

    logic [IDX_W-1:0] addr_inc;
    logic [IDX_W-1:0] waddr;
    slot_wr_t         wr;
    slot_rd_t         rd;
    logic             hit;
    logic             last;

    function automatic logic [3:0] nib(input logic [IDX_W-1:0] a);
        logic [EXT_W-1:0] e;
        e = EXT_W'(a);
        return e[3:0];
    endfunction

    ttrr_slot_mem #(
        .SLOTS (SLOTS),
        .IDX_W (IDX_W)
    ) u_slot_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .raddr (addr_reg),
        .waddr (waddr),
        .wr    (wr),
        .rd    (rd)
    );

    assign addr_inc  = (addr_reg == IDX_W'(SLOTS - 1)) ? '0 : addr_reg + 1'b1;
    assign last      = (count_reg == IDX_W'(SLOTS - 1));
    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    // shared match compare
    always_comb
    begin
        case (cmd_reg)
            CMD_CREATE:    hit = (rd.stat == SLOT_UNUSED);
            CMD_TERMINATE: hit = (rd.id == target_reg);
            default:       hit = (rd.stat == SLOT_READY);
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        target_next     = target_reg;
        addr_next       = addr_reg;
        count_next      = count_reg;
        first_next      = first_reg;
        cur_next        = cur_reg;
        cur_stat_next   = cur_stat_reg;
        cur_id_next     = cur_id_reg;
        running_next    = running_reg;
        id_counter_next = id_counter_reg;
        res_next        = res_reg;
        res_data_next   = res_data_reg;
        res_valid_next  = res_valid_reg && !res_ready;
        waddr           = addr_reg;
        wr              = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next    = cmd_data.cmd;
                    target_next = cmd_data.target_id;
                    count_next  = '0;
                    case (cmd_data.cmd)
                        CMD_CREATE, CMD_TERMINATE:
                        begin
                            if (cmd_data.cmd == CMD_TERMINATE && cmd_data.target_id == 32'd0)
                            begin
                                res_next   = '{RES_KERNEL, 4'd0, 32'd0, 4'd0};
                                state_next = S_RESULT;
                            end
                            else
                            begin
                                addr_next  = '0;
                                first_next = 1'b0;
                                state_next = S_LOAD;
                            end
                        end
                        CMD_SCHEDULE:
                        begin
                            addr_next  = running_reg;
                            first_next = 1'b1;
                            state_next = S_LOAD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_LOAD:
            begin
                state_next = S_CHECK;
            end

            S_CHECK:
            begin
                if (first_reg)
                begin
                    // running slot snapshot, then scan from the slot after it
                    cur_next      = addr_reg;
                    cur_stat_next = rd.stat;
                    cur_id_next   = rd.id;
                    addr_next     = addr_inc;
                    count_next    = '0;
                    first_next    = 1'b0;
                    state_next    = S_LOAD;
                end
                else if (hit)
                begin
                    wr.stat_we = 1'b1;
                    case (cmd_reg)
                        CMD_CREATE:
                        begin
                            wr.stat         = SLOT_READY;
                            wr.id_we        = 1'b1;
                            wr.id           = id_counter_reg;
                            id_counter_next = id_counter_reg + 32'd1;
                            res_next        = '{RES_OK, nib(addr_reg), id_counter_reg, 4'd0};
                            state_next      = S_RESULT;
                        end
                        CMD_TERMINATE:
                        begin
                            wr.stat    = SLOT_TERMINATED;
                            res_next   = '{RES_OK, nib(addr_reg), target_reg, 4'd0};
                            state_next = S_RESULT;
                        end
                        default:
                        begin
                            wr.stat      = SLOT_RUNNING;
                            running_next = addr_reg;
                            res_next     = '{RES_OK, nib(addr_reg), rd.id, nib(cur_reg)};
                            state_next   = (cur_stat_reg == SLOT_RUNNING) ? S_WRITE : S_RESULT;
                        end
                    endcase
                end
                else if (last)
                begin
                    case (cmd_reg)
                        CMD_CREATE:    res_next = '{RES_FULL, 4'd0, 32'd0, 4'd0};
                        CMD_TERMINATE: res_next = '{RES_NOT_FOUND, 4'd0, 32'd0, 4'd0};
                        default:
                            res_next = '{RES_NO_READY, nib(cur_reg), cur_id_reg, nib(cur_reg)};
                    endcase
                    state_next = S_RESULT;
                end
                else
                begin
                    addr_next  = addr_inc;
                    count_next = count_reg + 1'b1;
                    state_next = S_LOAD;
                end
            end

            S_WRITE:
            begin
                // previous running slot drops back to ready
                waddr      = cur_reg;
                wr.stat_we = 1'b1;
                wr.stat    = SLOT_READY;
                state_next = S_RESULT;
            end

            S_RESULT:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_valid_next = 1'b1;
                    res_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cmd_reg        <= CMD_CREATE;
            addr_reg       <= '0;
            count_reg      <= '0;
            first_reg      <= 1'b0;
            running_reg    <= '0;
            id_counter_reg <= 32'd1;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cmd_reg        <= cmd_next;
            addr_reg       <= addr_next;
            count_reg      <= count_next;
            first_reg      <= first_next;
            running_reg    <= running_next;
            id_counter_reg <= id_counter_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        target_reg   <= target_next;
        cur_reg      <= cur_next;
        cur_stat_reg <= cur_stat_next;
        cur_id_reg   <= cur_id_next;
        res_reg      <= res_next;
        res_data_reg <= res_data_next;
    end

endmodule

FILE: hw/rtl/ttrr_slot_mem.sv
// slot state and id memories with per-entry valid bits
`timescale 1ns / 1ps

module ttrr_slot_mem #(
    parameter int SLOTS = ttrr_pkg::SLOTS_DEF,
    parameter int IDX_W = $clog2(SLOTS)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [IDX_W-1:0]    raddr,
    input  logic [IDX_W-1:0]    waddr,
    input  ttrr_pkg::slot_wr_t  wr,
    output ttrr_pkg::slot_rd_t  rd
);
    import ttrr_pkg::*;

    logic [1:0]       stat_mem [SLOTS];
    logic [31:0]      id_mem [SLOTS];
    logic [SLOTS-1:0] stat_vld_reg;
    logic             stat_vq_reg;
    logic [IDX_W-1:0] raddr_q_reg;
    logic [1:0]       stat_q_reg;
    logic [31:0]      id_q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stat_vld_reg <= '0;
            stat_vq_reg  <= 1'b0;
            raddr_q_reg  <= '0;
        end
        else
        begin
            if (wr.stat_we)
            begin
                stat_vld_reg[waddr] <= 1'b1;
            end
            stat_vq_reg <= stat_vld_reg[raddr];
            raddr_q_reg <= raddr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.stat_we)
        begin
            stat_mem[waddr] <= wr.stat;
        end
        if (wr.id_we)
        begin
            id_mem[waddr] <= wr.id;
        end
        stat_q_reg <= stat_mem[raddr];
        id_q_reg   <= id_mem[raddr];
    end

    // unwritten entries read as their reset contents
    // a slot other than slot 0 gets its id on the first state write
    // slot 0 keeps the kernel id
    always_comb
    begin
        if (stat_vq_reg)
        begin
            rd.stat = stat_q_reg;
        end
        else if (raddr_q_reg == '0)
        begin
            rd.stat = SLOT_RUNNING;
        end
        else
        begin
            rd.stat = SLOT_UNUSED;
        end
        rd.id = (stat_vq_reg && raddr_q_reg != '0) ? id_q_reg : 32'd0;
    end

endmodule

FILE: hw/rtl/ttrr_checker.sv
// port-level checks for the round-robin task table, bound to the top level
`timescale 1ns / 1ps
`include "task_table_round_robin_macros.svh"

module ttrr_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           cmd_valid,
    input logic           cmd_ready,
    input ttrr_pkg::cmd_t cmd_data,
    input logic           res_valid,
    input logic           res_ready,
    input ttrr_pkg::res_t res_data
);
    import ttrr_pkg::*;

    logic cmd_defined;
    logic res_failed;
    logic res_zero;
    logic no_ready;
    logic same_slot;

    assign cmd_defined = (cmd_data.cmd == CMD_CREATE) || (cmd_data.cmd == CMD_TERMINATE)
                         || (cmd_data.cmd == CMD_SCHEDULE);
    assign res_failed  = (res_data.status == RES_FULL) || (res_data.status == RES_KERNEL)
                         || (res_data.status == RES_NOT_FOUND);
    assign res_zero    = (res_data.slot_index == 4'd0) && (res_data.task_id == 32'd0)
                         && (res_data.previous_slot == 4'd0);
    assign no_ready    = (res_data.status == RES_NO_READY);
    assign same_slot   = (res_data.slot_index == res_data.previous_slot);

    // stalled result transaction holds
    `TTRR_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_data))

    // a defined command drops cmd_ready in the cycle after it is accepted
    `TTRR_ASSERT_NEXT(a_busy_after_cmd, cmd_valid && cmd_ready && cmd_defined, !cmd_ready)

    // failed create or terminate names no slot
    `TTRR_ASSERT_IMP(a_err_fields, res_valid && res_failed, res_zero)

    // no switch leaves the running slot in both slot fields
    `TTRR_ASSERT_IMP(a_no_ready_same, res_valid && no_ready, same_slot)

endmodule

bind task_table_round_robin ttrr_checker u_ttrr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_data  (cmd_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
);

FILE: tb/sv/tb_top.sv
// self-checking testbench for the round-robin task table: directed table, then random commands
`timescale 1ns / 1ps

module tb_top;
    import ttrr_pkg::*;

    localparam int         NSLOTS        = SLOTS_DEF;
    localparam int         DIR_ROWS      = 25;
    localparam int         RANDOM_CMDS   = 1600;
    localparam int         HOLD_AT       = 40;
    localparam int         HOLD_OFF      = 300;
    localparam int         DRAIN         = 4 * NSLOTS + 40;
    localparam logic [1:0] CMD_UNDEFINED = 2'd3;

    typedef struct packed {
        logic typed;
        cmd_t c;
        res_t r;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd_data;
    logic res_valid;
    logic res_ready;
    res_t res_data;

    logic [1:0]  tbl_stat [NSLOTS];
    logic [31:0] tbl_id   [NSLOTS];
    int          cur_slot;
    logic [31:0] next_id;

    res_t     pending_res [$];
    dir_row_t dir_rows    [DIR_ROWS];
    int       status_seen [5];
    int       err_count;
    int       cmd_count;
    int       res_count;
    bit       stim_done;

    task_table_round_robin u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_data  (cmd_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    // applies one command to the shadow table; returns 0 when no result is due
    function automatic bit table_apply(input cmd_t c, output res_t r);
        int nxt;
        r = '0;
        case (c.cmd)
            CMD_CREATE:
            begin
                for (int i = 0; i < NSLOTS; i++)
                begin
                    if (tbl_stat[i] == SLOT_UNUSED)
                    begin
                        tbl_stat[i] = SLOT_READY;
                        tbl_id[i]   = next_id;
                        next_id     = next_id + 32'd1;
                        r           = '{RES_OK, 4'(i), tbl_id[i], 4'd0};
                        return 1'b1;
                    end
                end
                r.status = RES_FULL;
                return 1'b1;
            end
            CMD_TERMINATE:
            begin
                if (c.target_id == 32'd0)
                begin
                    r.status = RES_KERNEL;
                    return 1'b1;
                end
                for (int i = 0; i < NSLOTS; i++)
                begin
                    if (tbl_id[i] == c.target_id)
                    begin
                        tbl_stat[i] = SLOT_TERMINATED;
                        r           = '{RES_OK, 4'(i), c.target_id, 4'd0};
                        return 1'b1;
                    end
                end
                r.status = RES_NOT_FOUND;
                return 1'b1;
            end
            CMD_SCHEDULE:
            begin
                nxt = (cur_slot + 1) % NSLOTS;
                for (int n = 0; n < NSLOTS; n++)
                begin
                    if (tbl_stat[nxt] == SLOT_READY)
                    begin
                        if (tbl_stat[cur_slot] == SLOT_RUNNING)
                            tbl_stat[cur_slot] = SLOT_READY;
                        tbl_stat[nxt] = SLOT_RUNNING;
                        r             = '{RES_OK, 4'(nxt), tbl_id[nxt], 4'(cur_slot)};
                        cur_slot      = nxt;
                        return 1'b1;
                    end
                    nxt = (nxt + 1) % NSLOTS;
                end
                r = '{RES_NO_READY, 4'(cur_slot), tbl_id[cur_slot], 4'(cur_slot)};
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    // kills of live ids kept rare so scheduling stays interesting for most of the run
    function automatic cmd_t draw_command();
        cmd_t c;
        int   pick;
        int   sub;
        int   live [$];
        c.cmd       = CMD_UNDEFINED;
        c.target_id = $urandom;
        pick        = $urandom_range(0, 99);
        if (pick < 20)
            c.cmd = CMD_CREATE;
        else if (pick < 60)
            c.cmd = CMD_SCHEDULE;
        else if (pick < 95)
        begin
            c.cmd = CMD_TERMINATE;
            sub   = $urandom_range(0, 99);
            for (int i = 1; i < NSLOTS; i++)
                if (tbl_stat[i] != SLOT_UNUSED)
                    live.push_back(i);
            if (sub < 3 && live.size() > 0)
                c.target_id = tbl_id[live[$urandom_range(0, live.size() - 1)]];
            else if (sub < 10)
                c.target_id = 32'd0;
            else if (sub < 15)
                c.target_id = $urandom_range(10, 40);
        end
        return c;
    endfunction

    function automatic int idle_cycles(input int n);
        if ((n / 64) % 3 == 2)
            return 0;
        return $urandom_range(0, 7);
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            err_count++;
        end
    endtask

    initial
    begin : clock_gen
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin : sender
        dir_row_t row;
        res_t     r;
        int       gap;
        int       rand_sent;
        bit       produces;
        cmd_valid = 1'b0;
        cmd_data  = '0;
        cmd_count = 0;
        stim_done = 1'b0;
        for (int i = 0; i < NSLOTS; i++)
        begin
            tbl_stat[i] = SLOT_UNUSED;
            tbl_id[i]   = 32'd0;
        end
        tbl_stat[0] = SLOT_RUNNING;
        cur_slot    = 0;
        next_id     = 32'd1;
        rand_sent   = 0;

        dir_rows[0]  = '{1'b1, '{CMD_SCHEDULE, 32'd0}, '{RES_NO_READY, 4'd0, 32'd0, 4'd0}};
        dir_rows[1]  = '{1'b1, '{CMD_TERMINATE, 32'd0}, '{RES_KERNEL, 4'd0, 32'd0, 4'd0}};
        dir_rows[2]  = '{1'b1, '{CMD_TERMINATE, 32'hFFFF_FFFF},
                         '{RES_NOT_FOUND, 4'd0, 32'd0, 4'd0}};
        dir_rows[3]  = '{1'b0, '{CMD_UNDEFINED, 32'hFFFF_FFFF}, '0};
        dir_rows[4]  = '{1'b1, '{CMD_CREATE, 32'hFFFF_FFFF}, '{RES_OK, 4'd1, 32'd1, 4'd0}};
        dir_rows[5]  = '{1'b0, '{CMD_CREATE, 32'd0}, '0};
        dir_rows[6]  = '{1'b0, '{CMD_SCHEDULE, 32'hFFFF_FFFF}, '0};
        // running task killed, killed again, then switched away from
        dir_rows[7]  = '{1'b0, '{CMD_TERMINATE, 32'd1}, '0};
        dir_rows[8]  = '{1'b0, '{CMD_TERMINATE, 32'd1}, '0};
        dir_rows[9]  = '{1'b0, '{CMD_SCHEDULE, 32'd0}, '0};
        dir_rows[10] = '{1'b0, '{CMD_SCHEDULE, 32'd0}, '0};
        for (int k = 11; k < DIR_ROWS - 1; k++)
            dir_rows[k] = '{1'b0, '{CMD_CREATE, 32'd0}, '0};
        dir_rows[DIR_ROWS - 1] = '{1'b1, '{CMD_CREATE, 32'd0}, '{RES_FULL, 4'd0, 32'd0, 4'd0}};

        wait (rst_n);
        @(posedge clk);
        while (rand_sent < RANDOM_CMDS)
        begin
            if (cmd_count < DIR_ROWS)
                row = dir_rows[cmd_count];
            else
            begin
                row.typed = 1'b0;
                row.c     = draw_command();
                row.r     = '0;
            end
            gap = idle_cycles(cmd_count);
            if (gap > 0)
            begin
                cmd_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            cmd_valid <= 1'b1;
            cmd_data  <= row.c;
            @(posedge clk);
            while (!cmd_ready)
                @(posedge clk);
            produces = table_apply(row.c, r);
            if (produces)
                pending_res.push_back(row.typed ? row.r : r);
            if (produces && cmd_count >= DIR_ROWS)
                rand_sent++;
            cmd_count++;
        end
        cmd_valid <= 1'b0;
        stim_done = 1'b1;
    end

    initial
    begin : receiver
        res_t want;
        int   stall;
        res_ready = 1'b0;
        res_count = 0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            // one long hold-off so the block backs up into the command side
            stall = (res_count == HOLD_AT) ? HOLD_OFF : idle_cycles(res_count);
            if (stall > 0)
            begin
                res_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ready <= 1'b1;
            @(posedge clk);
            while (!res_valid)
                @(posedge clk);
            res_count++;
            if (pending_res.size() == 0)
            begin
                $error("unexpected transaction: status 0x%0h slot 0x%0h id 0x%0h",
                       res_data.status, res_data.slot_index, res_data.task_id);
                err_count++;
            end
            else
            begin
                want = pending_res.pop_front();
                status_seen[want.status]++;
                check_field("status", 32'(want.status), 32'(res_data.status));
                check_field("slot_index", 32'(want.slot_index), 32'(res_data.slot_index));
                check_field("task_id", want.task_id, res_data.task_id);
                check_field("previous_slot", 32'(want.previous_slot),
                            32'(res_data.previous_slot));
            end
        end
    end

    initial
    begin : run_control
        rst_n     = 1'b0;
        err_count = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        wait (stim_done && pending_res.size() == 0);
        repeat (DRAIN) @(posedge clk);
        if (pending_res.size() != 0)
        begin
            $error("%0d expected transactions never arrived", pending_res.size());
            err_count++;
        end
        $display("covered %0d commands and %0d results, one %0d-cycle receiver hold-off",
                 cmd_count, res_count, HOLD_OFF);
        $display("ok %0d, table full %0d, kernel refused %0d, unknown id %0d, none ready %0d",
                 status_seen[RES_OK], status_seen[RES_FULL], status_seen[RES_KERNEL],
                 status_seen[RES_NOT_FOUND], status_seen[RES_NO_READY]);
        if (err_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin : watchdog
        #5_000_000;
        $error("run timed out");
        $display("FAILED: results differ");
        $finish;
    end

endmodule
